FILE: rtl/trl_pkg.sv
// Shared types and constants for the turn restriction lookup unit.
`default_nettype none

package trl_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 1024;
   localparam int DEFAULT_ID_BITS     = 32;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef enum logic [1:0] {
      DEC_NONE      = 2'd0,
      DEC_PROHIBIT  = 2'd1,
      DEC_ONLY_HIT  = 2'd2,
      DEC_ONLY_MISS = 2'd3
   } decided_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_SCAN_RD,
      ST_SCAN_CMP
   } trl_state_type;

endpackage

`default_nettype wire

FILE: rtl/turn_restriction_lookup_unit.sv
// Top level of the turn restriction lookup unit: config register and lookup core.
`default_nettype none

// Turn restriction lookup unit.
// Request channel: a transaction is taken at a clock edge with start high and
// busy low. req_action selects a table write (entry_index, from, via, to,
// only_kind stored directly, no response, busy stays low) or a turn query.
// A query raises busy and runs a lower-bound binary search over the first
// rule_count entries, then scans the entries whose from/via key matches.
// Every table read is issued in a read state and compared in the next state
// on the registered read data. A query holds busy through its search probes,
// at most floor(log2(rule_count)) + 1, and the entries read by the scan.
// The loader must keep entries sorted by from, via; the unit does not check
// or enforce this order.
// Response channel: rsp_valid pulses for one cycle with rsp_allowed and
// rsp_decided_by; the receiver cannot stall, busy drops in that same cycle.
// CSR channel: csr_rule_count is written when csr_valid and csr_ready are high;
// counts above TABLE_DEPTH are clamped. Write it only while the unit is idle.
// Reset (synchronous) clears rule_count and the sequencer; table contents are
// undefined until written.

module turn_restriction_lookup_unit import trl_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   parameter int ID_BITS     = DEFAULT_ID_BITS,
   localparam int IDX_W      = $clog2(TABLE_DEPTH),
   localparam int CNT_W      = $clog2(TABLE_DEPTH + 1),
   localparam int WORD_W     = 3 * ID_BITS + 1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_action,
   input  wire logic [IDX_W-1:0]   req_entry_index,
   input  wire logic [ID_BITS-1:0] req_from_segment,
   input  wire logic [ID_BITS-1:0] req_via_node,
   input  wire logic [ID_BITS-1:0] req_to_segment,
   input  wire logic               req_only_kind,
   output logic                    rsp_valid,
   output logic                    rsp_allowed,
   output logic [1:0]              rsp_decided_by,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [CNT_W-1:0]   csr_rule_count
);

   logic [CNT_W-1:0]  rule_count_ff, rule_count_in;
   logic [CNT_W-1:0]  count_clamped;

   logic              mem_wr_en;
   logic [IDX_W-1:0]  mem_wr_addr;
   logic [WORD_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [IDX_W-1:0]  mem_rd_addr;
   logic [WORD_W-1:0] mem_rd_data;

   // config is only legal while idle, so ready simply tracks that
   assign csr_ready     = !busy;
   assign rule_count_in = (csr_valid && csr_ready) ? csr_rule_count : rule_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_count_ff <= '0;
      end else begin
         rule_count_ff <= rule_count_in;
      end
   end

   // clamp so search and scan never index past the table
   assign count_clamped = (rule_count_ff > CNT_W'(TABLE_DEPTH)) ?
                          CNT_W'(TABLE_DEPTH) : rule_count_ff;

   trl_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_entry_index  (req_entry_index),
      .req_from_segment (req_from_segment),
      .req_via_node     (req_via_node),
      .req_to_segment   (req_to_segment),
      .req_only_kind    (req_only_kind),
      .rule_count       (count_clamped),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data),
      .mem_rd_en        (mem_rd_en),
      .mem_rd_addr      (mem_rd_addr),
      .mem_rd_data      (mem_rd_data),
      .rsp_valid        (rsp_valid),
      .rsp_allowed      (rsp_allowed),
      .rsp_decided_by   (rsp_decided_by)
   );

   // single table word per rule: {kind, to, via, from}
   trl_rule_mem #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (WORD_W)
   ) u_rule_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire

FILE: rtl/trl_rule_mem.sv
// Rule table memory: one write port, one read port, registered read data.
`default_nettype none

module trl_rule_mem import trl_pkg::*; #(
   parameter int DEPTH  = DEFAULT_TABLE_DEPTH,
   parameter int WIDTH  = 3 * DEFAULT_ID_BITS + 1,
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/trl_ctrl.sv
// Lookup sequencer: table writes, lower-bound search and matching-rule scan.
`default_nettype none

module trl_ctrl import trl_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   parameter int ID_BITS     = DEFAULT_ID_BITS,
   localparam int IDX_W      = $clog2(TABLE_DEPTH),
   localparam int CNT_W      = $clog2(TABLE_DEPTH + 1),
   localparam int WORD_W     = 3 * ID_BITS + 1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_action,
   input  wire logic [IDX_W-1:0]   req_entry_index,
   input  wire logic [ID_BITS-1:0] req_from_segment,
   input  wire logic [ID_BITS-1:0] req_via_node,
   input  wire logic [ID_BITS-1:0] req_to_segment,
   input  wire logic               req_only_kind,
   input  wire logic [CNT_W-1:0]   rule_count,
   output logic                    mem_wr_en,
   output logic [IDX_W-1:0]        mem_wr_addr,
   output logic [WORD_W-1:0]       mem_wr_data,
   output logic                    mem_rd_en,
   output logic [IDX_W-1:0]        mem_rd_addr,
   input  wire logic [WORD_W-1:0]  mem_rd_data,
   output logic                    rsp_valid,
   output logic                    rsp_allowed,
   output logic [1:0]              rsp_decided_by
);

   trl_state_type state_ff, state_in;

   logic [CNT_W-1:0]   lo_ff, lo_in;
   logic [CNT_W-1:0]   hi_ff, hi_in;
   logic               saw_only_ff, saw_only_in;
   logic [ID_BITS-1:0] qfrom_ff, qfrom_in;
   logic [ID_BITS-1:0] qvia_ff, qvia_in;
   logic [ID_BITS-1:0] qto_ff, qto_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_allowed_ff, rsp_allowed_in;
   decided_type        rsp_dec_ff, rsp_dec_in;

   logic               req_take;
   logic               query_take;
   logic [CNT_W-1:0]   mid;
   logic               lo_below_hi;
   logic               lo_below_cnt;
   logic [ID_BITS-1:0] rd_from;
   logic [ID_BITS-1:0] rd_via;
   logic [ID_BITS-1:0] rd_to;
   logic               rd_kind;
   logic               key_below;
   logic               key_match;
   logic               to_hit;

   assign busy       = (state_ff != ST_IDLE);
   assign req_take   = start && !busy;
   assign query_take = req_take && (req_action == ACT_QUERY);

   // writes go straight to the table while idle; slots past the depth are dropped
   assign mem_wr_en   = req_take && (req_action == ACT_WRITE) &&
                        (CNT_W'(req_entry_index) < CNT_W'(TABLE_DEPTH));
   assign mem_wr_addr = req_entry_index;
   assign mem_wr_data = {req_only_kind, req_to_segment, req_via_node, req_from_segment};

   assign mid          = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign lo_below_hi  = lo_ff < hi_ff;
   assign lo_below_cnt = lo_ff < rule_count;

   assign rd_from   = mem_rd_data[ID_BITS-1:0];
   assign rd_via    = mem_rd_data[2*ID_BITS-1:ID_BITS];
   assign rd_to     = mem_rd_data[3*ID_BITS-1:2*ID_BITS];
   assign rd_kind   = mem_rd_data[3*ID_BITS];
   assign key_below = {rd_from, rd_via} < {qfrom_ff, qvia_ff};
   assign key_match = (rd_from == qfrom_ff) && (rd_via == qvia_ff);
   assign to_hit    = (rd_to == qto_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (query_take) state_in = ST_SRCH_RD;
         end
         ST_SRCH_RD: begin
            state_in = lo_below_hi ? ST_SRCH_CMP : ST_SCAN_RD;
         end
         ST_SRCH_CMP: begin
            state_in = ST_SRCH_RD;
         end
         ST_SCAN_RD: begin
            state_in = lo_below_cnt ? ST_SCAN_CMP : ST_IDLE;
         end
         ST_SCAN_CMP: begin
            state_in = (!key_match || to_hit) ? ST_IDLE : ST_SCAN_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      saw_only_in    = saw_only_ff;
      qfrom_in       = qfrom_ff;
      qvia_in        = qvia_ff;
      qto_in         = qto_ff;
      rsp_valid_in   = 1'b0;
      rsp_allowed_in = rsp_allowed_ff;
      rsp_dec_in     = rsp_dec_ff;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = mid[IDX_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (query_take) begin
               lo_in       = '0;
               hi_in       = rule_count;
               saw_only_in = 1'b0;
               qfrom_in    = req_from_segment;
               qvia_in     = req_via_node;
               qto_in      = req_to_segment;
            end
         end
         ST_SRCH_RD: begin
            mem_rd_en = lo_below_hi;
         end
         ST_SRCH_CMP: begin
            if (key_below) lo_in = mid + 1'b1;
            else           hi_in = mid;
         end
         ST_SCAN_RD: begin
            mem_rd_en   = lo_below_cnt;
            mem_rd_addr = lo_ff[IDX_W-1:0];
            if (!lo_below_cnt) begin
               rsp_valid_in   = 1'b1;
               rsp_allowed_in = !saw_only_ff;
               rsp_dec_in     = saw_only_ff ? DEC_ONLY_MISS : DEC_NONE;
            end
         end
         ST_SCAN_CMP: begin
            if (!key_match) begin
               rsp_valid_in   = 1'b1;
               rsp_allowed_in = !saw_only_ff;
               rsp_dec_in     = saw_only_ff ? DEC_ONLY_MISS : DEC_NONE;
            end else if (to_hit) begin
               rsp_valid_in   = 1'b1;
               rsp_allowed_in = rd_kind;
               rsp_dec_in     = rd_kind ? DEC_ONLY_HIT : DEC_PROHIBIT;
            end else begin
               saw_only_in = saw_only_ff | rd_kind;
               lo_in       = lo_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      saw_only_ff    <= saw_only_in;
      qfrom_ff       <= qfrom_in;
      qvia_ff        <= qvia_in;
      qto_ff         <= qto_in;
      rsp_allowed_ff <= rsp_allowed_in;
      rsp_dec_ff     <= rsp_dec_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_allowed    = rsp_allowed_ff;
   assign rsp_decided_by = rsp_dec_ff;

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("response strobe longer than one cycle");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      query_take |=> busy)
      else $error("query accepted without going busy");

   a_search_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SRCH_RD) |-> (lo_ff <= hi_ff) && (hi_ff <= rule_count))
      else $error("search bounds crossed");

   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> !busy && !mem_rd_en)
      else $error("table write during lookup");

   a_rsp_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_in |=> (state_ff == ST_IDLE))
      else $error("response issued outside lookup end");

endmodule

`default_nettype wire

FILE: tb/turn_restriction_lookup_unit_tb.sv
// Self-checking testbench for the turn restriction lookup unit.
`timescale 1ns / 1ps

module turn_restriction_lookup_unit_tb;
   import trl_pkg::*;

   localparam int DEPTH          = DEFAULT_TABLE_DEPTH;
   localparam int RANDOM_ITEMS   = 740;
   localparam int DRAIN_CYCLES   = 4;     // writes give no response and leave busy low
   localparam int SETTLE_CYCLES  = 40;
   localparam int CYCLE_LIMIT    = 1500000;
   localparam logic [31:0] ID_MAX = '1;

   typedef struct packed {
      logic        allowed;
      decided_type dec;
   } turn_verdict_type;

   // directed plan: a row is either a request transaction or a rule_count write
   typedef enum logic {STEP_ITEM, STEP_CSR} step_kind_type;

   typedef struct packed {
      step_kind_type kind;
      logic          act;
      logic [9:0]    idx;
      logic [31:0]   from_id;
      logic [31:0]   via_id;
      logic [31:0]   to_id;
      logic          only;
      logic [10:0]   cnt;
      bit            typed;     // expected verdict given below, else predicted
      logic          allowed;
      decided_type   dec;
   } step_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        req_action = ACT_WRITE;
   logic [9:0]  req_entry_index = '0;
   logic [31:0] req_from_segment = '0;
   logic [31:0] req_via_node = '0;
   logic [31:0] req_to_segment = '0;
   logic        req_only_kind = 1'b0;
   logic        csr_valid = 1'b0;
   logic [10:0] csr_rule_count = '0;
   logic        busy;
   logic        rsp_valid;
   logic        rsp_allowed;
   logic [1:0]  rsp_decided_by;
   logic        csr_ready;

   // shadow copy of the rule table and the count register
   logic [31:0] rule_from [DEPTH];
   logic [31:0] rule_via  [DEPTH];
   logic [31:0] rule_to   [DEPTH];
   logic        rule_only [DEPTH];
   logic [10:0] live_count = '0;

   // scratch batch of rules for one random phase, plus the id pools it draws on
   logic [31:0] batch_from [DEPTH];
   logic [31:0] batch_via  [DEPTH];
   logic [31:0] batch_to   [DEPTH];
   logic        batch_only [DEPTH];
   logic [31:0] from_pool[$];
   logic [31:0] via_pool[$];
   logic [31:0] to_pool[$];

   turn_verdict_type pending_verdicts[$];
   int          failures = 0;
   int          items_sent = 0;
   int          cycle_count = 0;
   bit          calm = 1'b0;       // no sender gaps while set

   step_row_type directed_plan [29] = '{
      // after reset the count is zero: every turn allowed
      '{STEP_ITEM, ACT_QUERY, 10'd0,   32'd1,  32'd2,  32'd3,  1'b0, 11'd0, 1'b1, 1'b1, DEC_NONE},
      '{STEP_ITEM, ACT_WRITE, 10'd0,   32'd0,  32'd0,  32'd0,  1'b0, 11'd0, 1'b0, 1'b0, DEC_NONE},
      '{STEP_ITEM, ACT_WRITE, 10'd1,   32'd5,  32'd7,  32'd100, 1'b0, 11'd0, 1'b0, 1'b0, DEC_NONE},
      '{STEP_ITEM, ACT_WRITE, 10'd2,   32'd5,  32'd7,  32'd200, 1'b1, 11'd0, 1'b0, 1'b0, DEC_NONE},
      '{STEP_ITEM, ACT_WRITE, 10'd3,   32'd5,  32'd7,  32'd300, 1'b1, 11'd0, 1'b0, 1'b0, DEC_NONE},
      '{STEP_ITEM, ACT_WRITE, 10'd4,   32'd9,  32'd1,  ID_MAX, 1'b1, 11'd0, 1'b0, 1'b0, DEC_NONE},
      '{STEP_ITEM, ACT_WRITE, 10'd5,   ID_MAX, ID_MAX, ID_MAX, 1'b0, 11'd0, 1'b0, 1'b0, DEC_NONE},
      '{STEP_ITEM, ACT_WRITE, 10'h3FF, ID_MAX, 32'd0,  32'd0,  1'b1, 11'd0, 1'b0, 1'b0, DEC_NONE},
      // rules loaded but count still zero: empty table
      '{STEP_ITEM, ACT_QUERY, 10'd0,   32'd5,  32'd7,  32'd100, 1'b0, 11'd0, 1'b1, 1'b1, DEC_NONE},
      '{STEP_CSR,  ACT_WRITE, 10'd0,   32'd0,  32'd0,  32'd0,  1'b0, 11'd6, 1'b0, 1'b0, DEC_NONE},
      '{STEP_ITEM, ACT_QUERY, 10'd0,   32'd0,  32'd0,  32'd0,  1'b0, 11'd0, 1'b1, 1'b0, DEC_PROHIBIT},
      '{STEP_ITEM, ACT_QUERY, 10'd0,   32'd0,  32'd0,  32'd1,  1'b0, 11'd0, 1'b1, 1'b1, DEC_NONE},
      '{STEP_ITEM, ACT_QUERY, 10'd0,   32'd5,  32'd7,  32'd100, 1'b0, 11'd0, 1'b1, 1'b0, DEC_PROHIBIT},
      '{STEP_ITEM, ACT_QUERY, 10'd0,   32'd5,  32'd7,  32'd200, 1'b0, 11'd0, 1'b1, 1'b1, DEC_ONLY_HIT},
      '{STEP_ITEM, ACT_QUERY, 10'd0,   32'd5,  32'd7,  32'd300, 1'b0, 11'd0, 1'b1, 1'b1, DEC_ONLY_HIT},
      // ignored fields set on a query; only rules seen, none matches
      '{STEP_ITEM, ACT_QUERY, 10'h3FF, 32'd5,  32'd7,  32'd999, 1'b1, 11'd0, 1'b1, 1'b0, DEC_ONLY_MISS},
      '{STEP_ITEM, ACT_QUERY, 10'd0,   32'd9,  32'd1,  ID_MAX, 1'b0, 11'd0, 1'b1, 1'b1, DEC_ONLY_HIT},
      '{STEP_ITEM, ACT_QUERY, 10'd0,   32'd9,  32'd1,  32'd0,  1'b0, 11'd0, 1'b1, 1'b0, DEC_ONLY_MISS},
      '{STEP_ITEM, ACT_QUERY, 10'd0,   ID_MAX, ID_MAX, ID_MAX, 1'b0, 11'd0, 1'b1, 1'b0, DEC_PROHIBIT},
      '{STEP_ITEM, ACT_QUERY, 10'd0,   32'd5,  32'd6,  32'd100, 1'b0, 11'd0, 1'b1, 1'b1, DEC_NONE},
      '{STEP_CSR,  ACT_WRITE, 10'd0,   32'd0,  32'd0,  32'd0,  1'b0, 11'd1, 1'b0, 1'b0, DEC_NONE},
      '{STEP_ITEM, ACT_QUERY, 10'd0,   32'd5,  32'd7,  32'd999, 1'b0, 11'd0, 1'b1, 1'b1, DEC_NONE},
      '{STEP_ITEM, ACT_QUERY, 10'd0,   32'd0,  32'd0,  32'd0,  1'b0, 11'd0, 1'b1, 1'b0, DEC_PROHIBIT},
      // break the sort order: the search result is whatever its steps give
      '{STEP_ITEM, ACT_WRITE, 10'd2,   32'd0,  32'd0,  32'd50, 1'b1, 11'd0, 1'b0, 1'b0, DEC_NONE},
      '{STEP_CSR,  ACT_WRITE, 10'd0,   32'd0,  32'd0,  32'd0,  1'b0, 11'd6, 1'b0, 1'b0, DEC_NONE},
      '{STEP_ITEM, ACT_QUERY, 10'd0,   32'd5,  32'd7,  32'd300, 1'b0, 11'd0, 1'b0, 1'b0, DEC_NONE},
      '{STEP_ITEM, ACT_QUERY, 10'd0,   32'd0,  32'd0,  32'd50, 1'b0, 11'd0, 1'b0, 1'b0, DEC_NONE},
      '{STEP_ITEM, ACT_QUERY, 10'd0,   32'd0,  32'd0,  32'd0,  1'b0, 11'd0, 1'b0, 1'b0, DEC_NONE},
      '{STEP_CSR,  ACT_WRITE, 10'd0,   32'd0,  32'd0,  32'd0,  1'b0, 11'd0, 1'b0, 1'b0, DEC_NONE}
   };

   turn_restriction_lookup_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_entry_index (req_entry_index),
      .req_from_segment(req_from_segment),
      .req_via_node    (req_via_node),
      .req_to_segment  (req_to_segment),
      .req_only_kind   (req_only_kind),
      .rsp_valid       (rsp_valid),
      .rsp_allowed     (rsp_allowed),
      .rsp_decided_by  (rsp_decided_by),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_rule_count  (csr_rule_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Verdict for a turn against the shadow table: lower-bound search on the
   // (from, via) key over the live entries, then a scan of the matching run.
   function automatic turn_verdict_type judge_turn(logic [31:0] from_id,
                                                   logic [31:0] via_id,
                                                   logic [31:0] to_id);
      turn_verdict_type verdict;
      int          span;
      int          lo;
      int          hi;
      int          mid;
      int          i;
      bit          only_seen;
      span = (live_count > DEPTH) ? DEPTH : int'(live_count);
      lo = 0;
      hi = span;
      only_seen = 1'b0;
      verdict.allowed = 1'b1;
      verdict.dec = DEC_NONE;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (rule_from[mid] < from_id || (rule_from[mid] == from_id && rule_via[mid] < via_id))
            lo = mid + 1;
         else
            hi = mid;
      end
      for (i = lo; i < span; i++) begin
         if (rule_from[i] != from_id || rule_via[i] != via_id)
            break;
         if (rule_to[i] == to_id) begin
            verdict.allowed = rule_only[i];
            verdict.dec = rule_only[i] ? DEC_ONLY_HIT : DEC_PROHIBIT;
            return verdict;
         end
         if (rule_only[i])
            only_seen = 1'b1;
      end
      if (only_seen) begin
         verdict.allowed = 1'b0;
         verdict.dec = DEC_ONLY_MISS;
      end
      return verdict;
   endfunction

   // Ids lean toward the extremes so key compares see equal, min and max.
   function automatic logic [31:0] pick_id();
      int roll;
      roll = $urandom_range(0, 7);
      if (roll == 0)
         return '0;
      if (roll == 1)
         return ID_MAX;
      return $urandom;
   endfunction

   // One request transaction. Random sender gaps come first; start then stays
   // high until the edge where busy is low, which is the accepting edge.
   task automatic issue_item(logic act, logic [9:0] idx, logic [31:0] from_id,
                             logic [31:0] via_id, logic [31:0] to_id, logic only,
                             bit typed, logic want_allowed, decided_type want_dec);
      turn_verdict_type verdict;
      while (!calm && $urandom_range(0, 99) < 11) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_action       <= act;
      req_entry_index  <= idx;
      req_from_segment <= from_id;
      req_via_node     <= via_id;
      req_to_segment   <= to_id;
      req_only_kind    <= only;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      items_sent++;
      if (act == ACT_WRITE) begin
         rule_from[idx] = from_id;
         rule_via[idx]  = via_id;
         rule_to[idx]   = to_id;
         rule_only[idx] = only;
      end else begin
         verdict = judge_turn(from_id, via_id, to_id);
         if (typed) begin
            verdict.allowed = want_allowed;
            verdict.dec = want_dec;
         end
         pending_verdicts = {pending_verdicts, verdict};
      end
   endtask

   task automatic write_rule(logic [9:0] idx, logic [31:0] from_id, logic [31:0] via_id,
                             logic [31:0] to_id, logic only);
      issue_item(ACT_WRITE, idx, from_id, via_id, to_id, only, 1'b0, 1'b0, DEC_NONE);
   endtask

   // entry_index and only_kind are don't-care on a query, so they get noise
   task automatic query_turn(logic [31:0] from_id, logic [31:0] via_id, logic [31:0] to_id);
      issue_item(ACT_QUERY, 10'($urandom_range(0, DEPTH - 1)), from_id, via_id, to_id,
                 1'($urandom_range(0, 1)), 1'b0, 1'b0, DEC_NONE);
   endtask

   // rule_count is only written with the unit idle and every verdict back
   task automatic set_rule_count(logic [10:0] count);
      start <= 1'b0;
      while (pending_verdicts.size() != 0 || busy)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid      <= 1'b1;
      csr_rule_count <= count;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid  <= 1'b0;
      live_count = count;
   endtask

   // Fill the batch from small id pools so keys repeat and junctions carry
   // several rules; sorted by (from, via) unless a broken table is wanted.
   task automatic build_batch(int count, int nf, int nv, int nt, bit keep_sorted);
      int          i;
      int          j;
      logic [31:0] kf;
      logic [31:0] kv;
      logic [31:0] kt;
      logic        ko;
      from_pool.delete();
      via_pool.delete();
      to_pool.delete();
      repeat (nf) from_pool = {from_pool, pick_id()};
      repeat (nv) via_pool = {via_pool, pick_id()};
      repeat (nt) to_pool = {to_pool, pick_id()};
      for (i = 0; i < count; i++) begin
         batch_from[i] = from_pool[$urandom_range(0, nf - 1)];
         batch_via[i]  = via_pool[$urandom_range(0, nv - 1)];
         batch_to[i]   = ($urandom_range(0, 9) < 8) ? to_pool[$urandom_range(0, nt - 1)]
                                                    : pick_id();
         batch_only[i] = 1'($urandom_range(0, 1));
      end
      if (keep_sorted) begin
         for (i = 1; i < count; i++) begin
            kf = batch_from[i];
            kv = batch_via[i];
            kt = batch_to[i];
            ko = batch_only[i];
            j = i - 1;
            while (j >= 0 && (batch_from[j] > kf || (batch_from[j] == kf && batch_via[j] > kv)))
            begin
               batch_from[j + 1] = batch_from[j];
               batch_via[j + 1]  = batch_via[j];
               batch_to[j + 1]   = batch_to[j];
               batch_only[j + 1] = batch_only[j];
               j--;
            end
            batch_from[j + 1] = kf;
            batch_via[j + 1]  = kv;
            batch_to[j + 1]   = kt;
            batch_only[j + 1] = ko;
         end
      end
   endtask

   task automatic load_batch(int count);
      int i;
      for (i = 0; i < count; i++)
         write_rule(10'(i), batch_from[i], batch_via[i], batch_to[i], batch_only[i]);
   endtask

   // Mostly queries on keys that exist, some on random keys, and a few stray
   // rule writes mixed in (these may leave the table unsorted).
   task automatic query_burst(int count);
      logic [31:0] from_id;
      logic [31:0] via_id;
      logic [31:0] to_id;
      repeat (count) begin
         if ($urandom_range(0, 99) < 12) begin
            write_rule(10'($urandom_range(0, DEPTH - 1)), pick_id(), pick_id(), pick_id(),
                       1'($urandom_range(0, 1)));
         end else begin
            from_id = ($urandom_range(0, 9) < 8) ?
                      from_pool[$urandom_range(0, from_pool.size() - 1)] : pick_id();
            via_id  = ($urandom_range(0, 9) < 8) ?
                      via_pool[$urandom_range(0, via_pool.size() - 1)] : pick_id();
            to_id   = ($urandom_range(0, 9) < 7) ?
                      to_pool[$urandom_range(0, to_pool.size() - 1)] : pick_id();
            query_turn(from_id, via_id, to_id);
         end
      end
   endtask

   // Response checker: the receiver never stalls, so every strobe is a
   // transaction and must match the oldest outstanding verdict.
   always @(posedge clock) begin
      turn_verdict_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_verdicts.size() == 0) begin
            $error("response with no query outstanding: allowed=%0b decided_by=%0d",
                   rsp_allowed, rsp_decided_by);
            failures++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_allowed !== want.allowed) begin
               $error("allowed: expected %0b, got %0b", want.allowed, rsp_allowed);
               failures++;
            end
            if (rsp_decided_by !== want.dec) begin
               $error("decided_by: expected %0d, got %0d", want.dec, rsp_decided_by);
               failures++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int base;
      int phase;
      int size;
      int roll;
      bit keep_sorted;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      foreach (directed_plan[r]) begin
         if (directed_plan[r].kind == STEP_CSR)
            set_rule_count(directed_plan[r].cnt);
         else
            issue_item(directed_plan[r].act, directed_plan[r].idx, directed_plan[r].from_id,
                       directed_plan[r].via_id, directed_plan[r].to_id, directed_plan[r].only,
                       directed_plan[r].typed, directed_plan[r].allowed, directed_plan[r].dec);
      end

      // random phases: load a small table, set the count, then query it
      base = items_sent;
      phase = 0;
      while (items_sent - base < RANDOM_ITEMS) begin
         calm = (phase >= 4 && phase < 8);
         roll = $urandom_range(0, 19);
         if (roll == 0)
            size = 0;
         else if (roll < 3)
            size = $urandom_range(17, 64);
         else
            size = $urandom_range(1, 16);
         keep_sorted = ($urandom_range(0, 9) != 0);
         build_batch(size, $urandom_range(1, 4), $urandom_range(1, 3), $urandom_range(2, 4),
                     keep_sorted);
         load_batch(size);
         if (keep_sorted && $urandom_range(0, 3) != 0)
            set_rule_count(11'(size));
         else
            set_rule_count(11'($urandom_range(0, size)));
         query_burst($urandom_range(10, 40));
         phase++;
      end
      calm = 1'b0;

      start <= 1'b0;
      while (pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
